// ===== sv/rpm_pkg.sv =====
`default_nettype none
package rpm_pkg;

    localparam int CAPACITY = 64;
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = SAMPLE_W + 1;
    localparam int COUNT_W  = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    typedef logic signed [SAMPLE_W-1:0] t_word;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [IDX_W-1:0]           t_idx;

    typedef struct packed {
        logic ins;   // insert request this cycle
        logic live;  // cell holds a stored entry
        logic tail;  // cell is the first free slot
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== sv/running_prefix_median_top.sv =====
// Throughput: one request per cycle unless m_tready stalls the pipe; the cell row inserts
// a sample, then the middle entries are picked and registered, and then they are added.
// Back-pressure on m_tready stalls the whole pipe and s_tready together.
// Reset (i_rst_n low, synchronous) empties the store and clears all valid flags;
// stored sample values are not reset.
`default_nettype none
module running_prefix_median_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [rpm_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] sample
    input  wire logic [0:0]  s_tuser,   // [0] restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [rpm_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [32:0] median_twice, [39:33] sample_count
    output logic [0:0]       m_tuser    // [0] refused
);
    import rpm_pkg::*;

    logic  adv;
    logic  acc;
    t_word sample;
    t_cnt  n_eff;
    logic  full;
    t_cnt  n_count;

    t_cnt  r_count;
    logic  r_s1_v;
    t_cnt  r_s1_cnt;
    logic  r_s1_ref;
    logic  r_s2_v;
    t_word r_s2_lo;
    t_word r_s2_hi;
    t_cnt  r_s2_cnt;
    logic  r_s2_ref;
    logic  r_out_v;
    logic signed [MEDIAN_W-1:0] r_out_med;
    logic  [COUNT_W-1:0]        r_out_cnt;
    logic  r_out_ref;

    t_word     vals  [CAPACITY];
    logic      shift [CAPACITY];
    t_cell_ctl ctl   [CAPACITY];
    t_idx      lo_idx;
    t_idx      hi_idx;
    t_word     lo_val;
    t_word     hi_val;
    t_cnt      cnt_m1;

    assign adv      = !r_out_v || m_tready;
    assign s_tready = adv && i_rst_n;
    assign acc      = s_tvalid && s_tready;
    assign sample   = s_tdata;

    assign n_eff   = s_tuser[0] ? '0 : r_count;
    assign full    = (n_eff == CNT_W'(CAPACITY));
    assign n_count = full ? n_eff : n_eff + CNT_W'(1);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign ctl[g].ins  = acc && !full;
            assign ctl[g].live = (CNT_W'(g) < n_eff);
            assign ctl[g].tail = (CNT_W'(g) == n_eff);
            if (g == 0) begin : g_first
                rpm_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (ctl[g]),
                    .i_sample     (sample),
                    .i_left_val   ('0),
                    .i_left_shift (1'b0),
                    .o_val        (vals[g]),
                    .o_shift      (shift[g])
                );
            end else begin : g_rest
                rpm_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (ctl[g]),
                    .i_sample     (sample),
                    .i_left_val   (vals[g-1]),
                    .i_left_shift (shift[g-1]),
                    .o_val        (vals[g]),
                    .o_shift      (shift[g])
                );
            end
        end
    endgenerate

    // lower middle at (n-1)/2, upper middle at n/2
    assign cnt_m1 = r_s1_cnt - CNT_W'(1);
    assign lo_idx = IDX_W'(cnt_m1 >> 1);
    assign hi_idx = IDX_W'(r_s1_cnt >> 1);

    rpm_pick u_pick_lo (.i_vals(vals), .i_idx(lo_idx), .o_val(lo_val));
    rpm_pick u_pick_hi (.i_vals(vals), .i_idx(hi_idx), .o_val(hi_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            if (acc) begin
                r_count <= n_count;
            end
            r_s1_v  <= acc;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_cnt  <= n_count;
            r_s1_ref  <= full;
            r_s2_lo   <= lo_val;
            r_s2_hi   <= hi_val;
            r_s2_cnt  <= r_s1_cnt;
            r_s2_ref  <= r_s1_ref;
            r_out_med <= {r_s2_lo[SAMPLE_W-1], r_s2_lo} + {r_s2_hi[SAMPLE_W-1], r_s2_hi};
            r_out_cnt <= COUNT_W'(r_s2_cnt);
            r_out_ref <= r_s2_ref;
        end
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = {r_out_cnt, r_out_med};
    assign m_tuser  = r_out_ref;

endmodule
`default_nettype wire

// ===== sv/rpm_cell.sv =====
`default_nettype none
module rpm_cell (
    input  wire logic              i_clk,
    input  wire rpm_pkg::t_cell_ctl i_ctl,
    input  wire rpm_pkg::t_word    i_sample,
    input  wire rpm_pkg::t_word    i_left_val,
    input  wire logic              i_left_shift,
    output rpm_pkg::t_word         o_val,
    output logic                   o_shift
);
    import rpm_pkg::*;

    t_word r_val;
    t_word n_val;
    logic  wr;

    // entry moves up when it is greater than the new sample
    assign o_shift = i_ctl.live && (r_val > i_sample);
    assign wr      = i_ctl.ins && (o_shift || i_ctl.tail);
    assign n_val   = i_left_shift ? i_left_val : i_sample;
    assign o_val   = r_val;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_val <= n_val;
        end
    end

endmodule
`default_nettype wire

// ===== sv/rpm_pick.sv =====
`default_nettype none
module rpm_pick (
    input  wire rpm_pkg::t_word i_vals [rpm_pkg::CAPACITY],
    input  wire rpm_pkg::t_idx  i_idx,
    output rpm_pkg::t_word      o_val
);
    import rpm_pkg::*;

    t_word masked [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_mask
            assign masked[g] = (i_idx == IDX_W'(g)) ? i_vals[g] : '0;
        end
    endgenerate

    always_comb begin
        o_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_val = o_val | masked[k];
        end
    end

endmodule
`default_nettype wire

// ===== sv/rpm_check.sv =====
`default_nettype none
module rpm_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser
);
    import rpm_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[39:33] == COUNT_W'(CAPACITY))
        else $error("refused without a full store");

endmodule

bind running_prefix_median_top rpm_check u_rpm_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
